// File: hdl/u4dc_pkg.sv
// Types, request codes and character helpers for the UTF-8 four-character dictionary counter.
// No dependencies; used by utf8_four_char_dictionary_counter.
package u4dc_pkg;

   // request codes
   typedef enum logic [1:0] {
      REQ_TEXT  = 2'd0,
      REQ_START = 2'd1,
      REQ_KEY   = 2'd2,
      REQ_READ  = 2'd3
   } req_code_type;

   localparam int IDX_BITS = 6;
   localparam int OUT_BITS = 32;

   // two bits of (length - 1) per upper nibble of the lead byte, selected by nibble * 2
   localparam logic [31:0] LEN_TABLE  = 32'hE500_0000;
   localparam logic [7:0]  NIBBLE_SEL = 8'h1E;

   typedef struct packed {
      req_code_type          req_type;
      logic [7:0]            text_byte;
      logic [IDX_BITS-1:0]   entry_index;
      logic                  key_half;
      logic [63:0]           key_bytes;
      logic [4:0]            key_length;
   } req_item_type;

   typedef struct packed {
      logic                  hit;
      logic [IDX_BITS-1:0]   hit_index;
      logic [OUT_BITS-1:0]   count_value;
   } rsp_item_type;

   // character length in bytes from the lead byte
   function automatic logic [2:0] char_len(input logic [7:0] lead);
      logic [7:0]  sel;
      logic [31:0] shifted;
      sel     = (lead >> 3) & NIBBLE_SEL;
      shifted = LEN_TABLE >> sel[4:0];
      return {1'b0, shifted[1:0]} + 3'd1;
   endfunction

   // single-byte whitespace: tab to carriage return, and space
   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

endpackage

// File: hdl/utf8_four_char_dictionary_counter.sv
// Top level of the UTF-8 four-character dictionary counter: decoder, window, key cells,
// priority encoder and count store. Depends on u4dc_pkg.
//
// One request is taken in every clock cycle: busy is high only while reset is applied and in the
// cycle after it. Every request gives exactly one result, strobed on rsp_valid for one cycle
// once it has passed the stages below; the receiver cannot stall, so nothing backs up. The path
// runs through five registered stages: character decode and window shift, window concatenation,
// a parallel compare in every dictionary entry, a priority encode with the count-store read,
// and the count update. Count reads and updates use separate count-store read and write ports with
// forwarding of the last write, so back-to-back hits on the same entry count correctly. Counts reset
// through per-entry valid bits, so no clearing pass follows reset.
module utf8_four_char_dictionary_counter #(
   parameter int DICT_ENTRIES = 64,
   parameter int COUNT_BITS   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  u4dc_pkg::req_item_type  req_data,
   output logic                    busy,
   output logic                    rsp_valid,
   output u4dc_pkg::rsp_item_type  rsp_data
);

   localparam int AW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
   localparam int EW = (AW > u4dc_pkg::IDX_BITS) ? AW : u4dc_pkg::IDX_BITS;
   localparam int CW = (COUNT_BITS > u4dc_pkg::OUT_BITS) ? COUNT_BITS : u4dc_pkg::OUT_BITS;

   // ---------------------------------------------------------------- input stage
   logic                   busy_ff;
   logic                   s0_vld_ff;
   u4dc_pkg::req_item_type s0_req_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_req_ff <= req_data;
   end

   assign busy = busy_ff;

   // ---------------------------------------------------------------- decoder and window
   logic [31:0] chr_ff  [4];
   logic [31:0] chr_in  [4];
   logic [2:0]  clen_ff [4];
   logic [2:0]  clen_in [4];
   logic [31:0] pend_ff;
   logic [31:0] pend_in;
   logic [1:0]  need_ff;
   logic [1:0]  need_in;
   logic [2:0]  psize_ff;
   logic [2:0]  psize_in;
   logic        push;
   logic [31:0] push_bytes;
   logic [2:0]  push_len;
   logic [2:0]  lead_len;
   logic [2:0]  lead_less;
   logic [2:0]  pos_wide;
   logic [1:0]  pos;
   logic        chk0;
   logic [7:0]  tbyte;

   always_comb begin
      chr_in     = chr_ff;
      clen_in    = clen_ff;
      pend_in    = pend_ff;
      need_in    = need_ff;
      psize_in   = psize_ff;
      push       = 1'b0;
      push_bytes = '0;
      push_len   = '0;
      tbyte      = s0_req_ff.text_byte;
      lead_len   = u4dc_pkg::char_len(tbyte);
      lead_less  = lead_len - 3'd1;
      pos_wide   = psize_ff - {1'b0, need_ff};
      pos        = pos_wide[1:0];
      if (s0_vld_ff) begin
         case (s0_req_ff.req_type)
            u4dc_pkg::REQ_TEXT: begin
               if (need_ff == 2'd0) begin
                  // lead byte
                  if (lead_len == 3'd1) begin
                     if (!u4dc_pkg::is_blank(tbyte)) begin
                        push       = 1'b1;
                        push_bytes = 32'(tbyte);
                        push_len   = 3'd1;
                     end
                  end else begin
                     pend_in  = 32'(tbyte);
                     need_in  = lead_less[1:0];
                     psize_in = lead_len;
                  end
               end else begin
                  // continuation byte, taken whatever its value
                  pend_in = pend_ff | (32'(tbyte) << {pos, 3'b000});
                  need_in = need_ff - 2'd1;
                  if (need_ff == 2'd1) begin
                     push       = 1'b1;
                     push_bytes = pend_in;
                     push_len   = psize_ff;
                  end
               end
            end
            u4dc_pkg::REQ_START: begin
               for (int i = 0; i < 4; i++) begin
                  clen_in[i] = 3'd0;
               end
               pend_in = '0;
               need_in = 2'd0;
            end
            default: begin
            end
         endcase
      end
      // window kept oldest first
      if (push) begin
         for (int i = 0; i < 3; i++) begin
            chr_in[i]  = chr_ff[i+1];
            clen_in[i] = clen_ff[i+1];
         end
         chr_in[3]  = push_bytes;
         clen_in[3] = push_len;
      end
      chk0 = push && (clen_ff[1] != 3'd0) && (clen_ff[2] != 3'd0) && (clen_ff[3] != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            clen_ff[i] <= 3'd0;
         end
         need_ff <= 2'd0;
      end else begin
         clen_ff <= clen_in;
         need_ff <= need_in;
      end
   end

   always_ff @(posedge clock) begin
      chr_ff   <= chr_in;
      pend_ff  <= pend_in;
      psize_ff <= psize_in;
   end

   // ---------------------------------------------------------------- stage 1: concatenation
   logic                   s1_vld_ff;
   logic                   s1_chk_ff;
   u4dc_pkg::req_item_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s1_chk_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
         s1_chk_ff <= chk0;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s0_req_ff;
   end

   logic [4:0]   off1;
   logic [4:0]   off2;
   logic [4:0]   off3;
   logic [4:0]   tot_in;
   logic [127:0] win_in;
   logic [127:0] mask_in;

   always_comb begin
      off1   = 5'(clen_ff[0]);
      off2   = off1 + 5'(clen_ff[1]);
      off3   = off2 + 5'(clen_ff[2]);
      tot_in = off3 + 5'(clen_ff[3]);
      win_in = 128'(chr_ff[0])
             | (128'(chr_ff[1]) << {off1, 3'b000})
             | (128'(chr_ff[2]) << {off2, 3'b000})
             | (128'(chr_ff[3]) << {off3, 3'b000});
      for (int p = 0; p < 16; p++) begin
         mask_in[p*8 +: 8] = (5'(p) < tot_in) ? 8'hFF : 8'h00;
      end
   end

   // ---------------------------------------------------------------- stage 2: key cells
   logic                   s2_vld_ff;
   logic                   s2_chk_ff;
   u4dc_pkg::req_item_type s2_req_ff;
   logic [127:0]           win_ff;
   logic [127:0]           mask_ff;
   logic [4:0]             tot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s2_chk_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
         s2_chk_ff <= s1_chk_ff && s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_req_ff <= s1_req_ff;
      win_ff    <= win_in;
      mask_ff   <= mask_in;
      tot_ff    <= tot_in;
   end

   logic [63:0]             key_lo_ff [DICT_ENTRIES];
   logic [63:0]             key_hi_ff [DICT_ENTRIES];
   logic [4:0]              klen_ff   [DICT_ENTRIES];
   logic [EW-1:0]           idx2_ext;
   logic [AW-1:0]           addr2;
   logic                    key_wr;
   logic [DICT_ENTRIES-1:0] match_in;

   assign idx2_ext = EW'(s2_req_ff.entry_index);
   assign addr2    = idx2_ext[AW-1:0];
   assign key_wr   = s2_vld_ff && (s2_req_ff.req_type == u4dc_pkg::REQ_KEY)
                  && (32'(s2_req_ff.entry_index) < 32'(DICT_ENTRIES));

   // key lengths, zero disables an entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < DICT_ENTRIES; e++) begin
            klen_ff[e] <= 5'd0;
         end
      end else begin
         for (int e = 0; e < DICT_ENTRIES; e++) begin
            if (key_wr && (addr2 == AW'(e))) begin
               klen_ff[e] <= s2_req_ff.key_length;
            end
         end
      end
   end

   // key bytes, one half per write
   always_ff @(posedge clock) begin
      for (int e = 0; e < DICT_ENTRIES; e++) begin
         if (key_wr && (addr2 == AW'(e))) begin
            if (s2_req_ff.key_half) begin
               key_hi_ff[e] <= s2_req_ff.key_bytes;
            end else begin
               key_lo_ff[e] <= s2_req_ff.key_bytes;
            end
         end
      end
   end

   // every entry compares the window on its own
   always_comb begin
      for (int e = 0; e < DICT_ENTRIES; e++) begin
         match_in[e] = s2_chk_ff && (klen_ff[e] == tot_ff)
                    && ((({key_hi_ff[e], key_lo_ff[e]} ^ win_ff) & mask_ff) == 128'd0);
      end
   end

   // ---------------------------------------------------------------- stage 3: encode, count read
   logic                    s3_vld_ff;
   u4dc_pkg::req_item_type  s3_req_ff;
   logic [DICT_ENTRIES-1:0] match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
         match_ff  <= '0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
         match_ff  <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_req_ff <= s2_req_ff;
   end

   logic          hit3;
   logic [AW-1:0] hidx3;
   logic [EW-1:0] idx3_ext;
   logic [AW-1:0] cnt_addr;
   logic          rng3;

   // lowest matching entry wins
   always_comb begin
      hit3  = 1'b0;
      hidx3 = '0;
      for (int e = DICT_ENTRIES - 1; e >= 0; e--) begin
         if (match_ff[e]) begin
            hit3  = s3_vld_ff;
            hidx3 = AW'(e);
         end
      end
      idx3_ext = EW'(s3_req_ff.entry_index);
      rng3     = 32'(s3_req_ff.entry_index) < 32'(DICT_ENTRIES);
      cnt_addr = hit3 ? hidx3 : idx3_ext[AW-1:0];
   end

   logic [COUNT_BITS-1:0]   cnt_mem [DICT_ENTRIES];
   logic [DICT_ENTRIES-1:0] cnt_vld_ff;
   logic [COUNT_BITS-1:0]   cnt_rd_ff;
   logic                    cv_rd_ff;
   logic                    s4_vld_ff;
   logic                    s4_hit_ff;
   logic                    s4_rng_ff;
   logic [AW-1:0]           s4_idx_ff;
   u4dc_pkg::req_item_type  s4_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s4_hit_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
         s4_hit_ff <= hit3;
      end
   end

   always_ff @(posedge clock) begin
      s4_req_ff <= s3_req_ff;
      s4_idx_ff <= cnt_addr;
      s4_rng_ff <= rng3;
      cnt_rd_ff <= cnt_mem[cnt_addr];
      cv_rd_ff  <= cnt_vld_ff[cnt_addr];
   end

   // ---------------------------------------------------------------- stage 4: count update
   logic                  fwd_vld_ff;
   logic [AW-1:0]         fwd_idx_ff;
   logic [COUNT_BITS-1:0] fwd_cnt_ff;
   logic [COUNT_BITS-1:0] cur_cnt;
   logic [COUNT_BITS-1:0] wr_data;
   logic                  wr_en;
   logic                  is_read;
   logic [CW-1:0]         wide_cnt;
   logic [u4dc_pkg::OUT_BITS-1:0] clip_cnt;
   logic [EW-1:0]         idx4_ext;
   u4dc_pkg::rsp_item_type rsp_in;
   u4dc_pkg::rsp_item_type rsp_data_ff;
   logic                  rsp_valid_ff;

   always_comb begin
      // last write is not yet visible in the read data
      if (fwd_vld_ff && (fwd_idx_ff == s4_idx_ff)) begin
         cur_cnt = fwd_cnt_ff;
      end else if (cv_rd_ff) begin
         cur_cnt = cnt_rd_ff;
      end else begin
         cur_cnt = '0;
      end
      is_read = s4_req_ff.req_type == u4dc_pkg::REQ_READ;
      wr_en   = s4_vld_ff && (s4_hit_ff
             || ((s4_req_ff.req_type == u4dc_pkg::REQ_KEY) && s4_rng_ff));
      // saturating increment; a key write clears the count
      if (s4_hit_ff) begin
         wr_data = (cur_cnt == {COUNT_BITS{1'b1}}) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
      end else begin
         wr_data = '0;
      end
      wide_cnt = s4_hit_ff ? CW'(wr_data) : CW'(cur_cnt);
      clip_cnt = (wide_cnt > CW'({u4dc_pkg::OUT_BITS{1'b1}}))
               ? {u4dc_pkg::OUT_BITS{1'b1}} : wide_cnt[u4dc_pkg::OUT_BITS-1:0];
      idx4_ext = EW'(s4_idx_ff);
      rsp_in   = '0;
      if (s4_hit_ff) begin
         rsp_in.hit         = 1'b1;
         rsp_in.hit_index   = idx4_ext[u4dc_pkg::IDX_BITS-1:0];
         rsp_in.count_value = clip_cnt;
      end else if (is_read) begin
         rsp_in.hit_index   = s4_req_ff.entry_index;
         rsp_in.count_value = s4_rng_ff ? clip_cnt : '0;
      end
   end

   // count store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[s4_idx_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff   <= '0;
         fwd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            cnt_vld_ff[s4_idx_ff] <= 1'b1;
         end
         fwd_vld_ff   <= wr_en;
         rsp_valid_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      fwd_idx_ff  <= s4_idx_ff;
      fwd_cnt_ff  <= wr_data;
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: dv/utf8_four_char_dictionary_counter_tb.sv
// Self-checking testbench for the UTF-8 four-character dictionary counter: a directed table, then
// random text built from a small character set, key writes and count reads, with random gaps.
// Depends on u4dc_pkg and utf8_four_char_dictionary_counter.
module utf8_four_char_dictionary_counter_tb;

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      u4dc_pkg::req_item_type item;
      bit                     typed;
      u4dc_pkg::rsp_item_type rsp;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   u4dc_pkg::req_item_type req_data;
   logic                   busy;
   logic                   rsp_valid;
   u4dc_pkg::rsp_item_type rsp_data;

   // typed-in expectation travels with the item, sampled like the other inputs
   logic                   typed_flag;
   u4dc_pkg::rsp_item_type typed_rsp;

   // predictor state
   logic [31:0]  win_char [4];
   logic [2:0]   win_size [4];
   logic [1:0]   win_slot;
   logic [31:0]  asm_char;
   logic [1:0]   asm_left;
   logic [127:0] key_text [64];
   logic [4:0]   key_size [64];
   logic [31:0]  hit_count [64];

   u4dc_pkg::rsp_item_type awaited_answers [$];
   int           errors = 0;
   int           cycles = 0;

   // stimulus bookkeeping
   bit           key_seen [64][2];
   bit           key_from_vocab [64];
   int           key_chars [64][4];
   bit           idle_on = 1'b1;
   int           items_sent = 0;
   stim_row_type dir_rows [$];

   utf8_four_char_dictionary_counter i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int utf8_size(input logic [7:0] lead);
      case (lead[7:4])
         4'hF:       return 4;
         4'hE:       return 3;
         4'hC, 4'hD: return 2;
         default:    return 1;
      endcase
   endfunction

   function automatic bit white_byte(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic void clear_window();
      int i;
      for (i = 0; i < 4; i++) begin
         win_char[i] = '0;
         win_size[i] = '0;
      end
      win_slot = '0;
      asm_char = '0;
      asm_left = '0;
   endfunction

   function automatic void clear_dictionary();
      int i;
      clear_window();
      for (i = 0; i < 64; i++) begin
         key_text[i]  = '0;
         key_size[i]  = '0;
         hit_count[i] = '0;
      end
   endfunction

   // push a finished character and look the four-character window up
   function automatic u4dc_pkg::rsp_item_type window_lookup(input logic [31:0] chr,
                                                            input int n);
      u4dc_pkg::rsp_item_type r;
      logic [7:0]   seq [16];
      int           i, k, s, e, p, total;
      bit           same;
      r = '0;
      win_char[win_slot] = chr;
      win_size[win_slot] = n[2:0];
      win_slot = win_slot + 2'd1;
      total = 0;
      for (i = 0; i < 4; i++) begin
         s = (int'(win_slot) + i) % 4;
         if (win_size[s] == 3'd0) return r;
         for (k = 0; k < int'(win_size[s]); k++) seq[total + k] = win_char[s][8*k +: 8];
         total += int'(win_size[s]);
      end
      // lowest index wins
      for (e = 0; e < 64; e++) begin
         if (int'(key_size[e]) == total) begin
            same = 1'b1;
            for (p = 0; p < total; p++)
               if (key_text[e][8*p +: 8] != seq[p]) same = 1'b0;
            if (same) begin
               if (hit_count[e] != '1) hit_count[e] = hit_count[e] + 32'd1;
               r.hit         = 1'b1;
               r.hit_index   = e[5:0];
               r.count_value = hit_count[e];
               return r;
            end
         end
      end
      return r;
   endfunction

   function automatic u4dc_pkg::rsp_item_type dictionary_answer(
         input u4dc_pkg::req_item_type it);
      u4dc_pkg::rsp_item_type r;
      int           n, pos;
      r = '0;
      case (it.req_type)
         u4dc_pkg::REQ_TEXT: begin
            if (asm_left == 2'd0) begin
               n = utf8_size(it.text_byte);
               if (n == 1) begin
                  if (!white_byte(it.text_byte)) r = window_lookup({24'h0, it.text_byte}, 1);
               end else begin
                  asm_char = {24'h0, it.text_byte};
                  asm_left = 2'(n - 1);
               end
            end else begin
               // any byte value is taken as the next continuation byte
               n   = utf8_size(asm_char[7:0]);
               pos = n - int'(asm_left);
               asm_char[8*pos +: 8] = it.text_byte;
               asm_left = asm_left - 2'd1;
               if (asm_left == 2'd0) r = window_lookup(asm_char, n);
            end
         end
         u4dc_pkg::REQ_START: clear_window();
         u4dc_pkg::REQ_KEY: begin
            if (it.key_half) key_text[it.entry_index][127:64] = it.key_bytes;
            else key_text[it.entry_index][63:0] = it.key_bytes;
            key_size[it.entry_index]  = it.key_length;
            hit_count[it.entry_index] = '0;
         end
         default: begin
            r.hit_index   = it.entry_index;
            r.count_value = hit_count[it.entry_index];
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- scoreboard

   always @(posedge clock) begin
      u4dc_pkg::rsp_item_type want;
      u4dc_pkg::rsp_item_type fresh;
      if (reset) begin
         clear_dictionary();
      end else begin
         // every accepted item queues one expected answer
         if (start && !busy) begin
            fresh = dictionary_answer(req_data);
            want  = typed_flag ? typed_rsp : fresh;
            awaited_answers.push_back(want);
         end
         if (rsp_valid) begin
            if (awaited_answers.size() == 0) begin
               $error("result with no item outstanding");
               errors++;
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
                  errors++;
               end
               if (rsp_data.hit_index !== want.hit_index) begin
                  $error("hit_index: expected %0d, got %0d", want.hit_index, rsp_data.hit_index);
                  errors++;
               end
               if (rsp_data.count_value !== want.count_value) begin
                  $error("count_value: expected %0d, got %0d",
                         want.count_value, rsp_data.count_value);
                  errors++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   function automatic u4dc_pkg::req_item_type rand_req();
      u4dc_pkg::req_item_type it;
      it.req_type    = u4dc_pkg::req_code_type'($urandom_range(0, 3));
      it.text_byte   = 8'($urandom_range(0, 255));
      it.entry_index = 6'($urandom_range(0, 63));
      it.key_half    = 1'($urandom_range(0, 1));
      it.key_bytes   = {$urandom, $urandom};
      it.key_length  = 5'($urandom_range(0, 31));
      return it;
   endfunction

   function automatic u4dc_pkg::req_item_type mk_req(input u4dc_pkg::req_code_type code,
                                                     input logic [7:0] b,
                                                     input logic [5:0] idx, input logic h,
                                                     input logic [63:0] kb,
                                                     input logic [4:0] n);
      u4dc_pkg::req_item_type it;
      it.req_type    = code;
      it.text_byte   = b;
      it.entry_index = idx;
      it.key_half    = h;
      it.key_bytes   = kb;
      it.key_length  = n;
      return it;
   endfunction

   function automatic u4dc_pkg::rsp_item_type mk_rsp(input logic h, input logic [5:0] idx,
                                                     input logic [31:0] cnt);
      u4dc_pkg::rsp_item_type r;
      r.hit         = h;
      r.hit_index   = idx;
      r.count_value = cnt;
      return r;
   endfunction

   // small character set: one- to four-byte characters and a stray continuation byte
   function automatic logic [31:0] vocab_bytes(input int k);
      case (k)
         0:       return 32'h0000_0078;
         1:       return 32'h0000_0079;
         2:       return 32'h0000_A9C3;
         3:       return 32'h00AC_82E2;
         4:       return 32'h8098_9FF0;
         default: return 32'h0000_0080;
      endcase
   endfunction

   function automatic int vocab_len(input int k);
      case (k)
         2:       return 2;
         3:       return 3;
         4:       return 4;
         default: return 1;
      endcase
   endfunction

   task automatic add_row(input u4dc_pkg::req_item_type it, input bit typed,
                          input u4dc_pkg::rsp_item_type r);
      stim_row_type row;
      row.item  = it;
      row.typed = typed;
      row.rsp   = r;
      dir_rows.push_back(row);
   endtask

   // present one item, with a random gap first, and wait for it to be taken
   task automatic send_item(input u4dc_pkg::req_item_type it, input bit typed,
                            input u4dc_pkg::rsp_item_type r);
      while (idle_on && $urandom_range(0, 99) < 34) begin
         start    <= 1'b0;
         req_data <= rand_req();
         @(posedge clock);
      end
      start      <= 1'b1;
      req_data   <= it;
      typed_flag <= typed;
      typed_rsp  <= r;
      if (it.req_type == u4dc_pkg::REQ_KEY) key_seen[it.entry_index][it.key_half] = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input logic [7:0] b);
      u4dc_pkg::req_item_type it;
      it = rand_req();
      it.req_type  = u4dc_pkg::REQ_TEXT;
      it.text_byte = b;
      send_item(it, 1'b0, '0);
   endtask

   task automatic send_key(input logic [5:0] idx, input logic h, input logic [63:0] kb,
                           input logic [4:0] n);
      u4dc_pkg::req_item_type it;
      it = rand_req();
      it.req_type    = u4dc_pkg::REQ_KEY;
      it.entry_index = idx;
      it.key_half    = h;
      it.key_bytes   = kb;
      it.key_length  = n;
      send_item(it, 1'b0, '0);
   endtask

   task automatic send_op(input u4dc_pkg::req_code_type code, input logic [5:0] idx);
      u4dc_pkg::req_item_type it;
      it = rand_req();
      it.req_type    = code;
      it.entry_index = idx;
      send_item(it, 1'b0, '0);
   endtask

   task automatic send_vocab(input int k);
      logic [31:0] cb;
      int          b;
      cb = vocab_bytes(k);
      for (b = 0; b < vocab_len(k); b++) send_text(cb[8*b +: 8]);
   endtask

   // key made of four characters from the set; upper half goes first so the
   // entry never needs a half that has not been written
   task automatic write_vocab_key(input int e);
      int          v [4];
      int          j, b, f, total;
      logic [127:0] kb;
      logic [31:0] cb;
      f = $urandom_range(0, 63);
      for (j = 0; j < 4; j++) v[j] = $urandom_range(0, 5);
      if ($urandom_range(0, 99) < 15 && key_from_vocab[f])
         for (j = 0; j < 4; j++) v[j] = key_chars[f][j];
      kb    = '0;
      total = 0;
      for (j = 0; j < 4; j++) begin
         cb = vocab_bytes(v[j]);
         for (b = 0; b < vocab_len(v[j]); b++) begin
            kb[8*total +: 8] = cb[8*b +: 8];
            total++;
         end
      end
      key_from_vocab[e] = 1'b0;
      if (total > 8) send_key(e[5:0], 1'b1, kb[127:64], key_seen[e][0] ? 5'(total) : 5'd0);
      send_key(e[5:0], 1'b0, kb[63:0], 5'(total));
      for (j = 0; j < 4; j++) key_chars[e][j] = v[j];
      key_from_vocab[e] = 1'b1;
   endtask

   // random bytes and length, length kept to halves already written
   task automatic write_noise_key(input int e);
      logic       h;
      logic [4:0] n;
      bit         w0, w1;
      h  = 1'($urandom_range(0, 1));
      w0 = key_seen[e][0] || !h;
      w1 = key_seen[e][1] || h;
      n  = 5'($urandom_range(0, 31));
      if (n != 5'd0 && !(w0 && (n <= 5'd8 || w1))) n = 5'd0;
      key_from_vocab[e] = 1'b0;
      send_key(e[5:0], h, {$urandom, $urandom}, n);
   endtask

   // a run of characters, often the characters of a stored key, with stray blanks
   task automatic emit_phrase();
      int e, tries, pick, j;
      e = -1;
      if ($urandom_range(0, 99) < 70)
         for (tries = 0; tries < 8 && e < 0; tries++) begin
            pick = $urandom_range(0, 63);
            if (key_from_vocab[pick]) e = pick;
         end
      for (j = 0; j < int'($urandom_range(0, 2)); j++) send_vocab($urandom_range(0, 5));
      for (j = 0; j < 4; j++) begin
         if ($urandom_range(0, 99) < 15)
            send_text(($urandom_range(0, 5) == 0) ? 8'h20 : 8'($urandom_range(9, 13)));
         send_vocab(e >= 0 ? key_chars[e][j] : int'($urandom_range(0, 5)));
      end
   endtask

   // sender holds off until every answer is back
   task automatic hold_until_drained();
      start <= 1'b0;
      do @(negedge clock); while (awaited_answers.size() != 0);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      int i, r, k, wait_cnt;
      logic [31:0] lead_chars;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      typed_flag = 1'b0;
      typed_rsp  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      add_row(mk_req(u4dc_pkg::REQ_READ, 8'h00, 6'd0, 1'b0, '0, 5'd0), 1'b1,
              mk_rsp(1'b0, 6'd0, 32'd0));
      add_row(mk_req(u4dc_pkg::REQ_READ, 8'h00, 6'd63, 1'b1, '0, 5'd0), 1'b1,
              mk_rsp(1'b0, 6'd63, 32'd0));
      add_row(mk_req(u4dc_pkg::REQ_KEY, 8'h00, 6'd0, 1'b0, 64'h6463_6261, 5'd4), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h61, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h20, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h62, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h09, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h63, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h64, 6'd0, 1'b0, '0, 5'd0), 1'b1,
              mk_rsp(1'b1, 6'd0, 32'd1));
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h0D, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h61, 6'd0, 1'b0, '0, 5'd0), 1'b0, '0);
      add_row(mk_req(u4dc_pkg::REQ_START, 8'h00, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_KEY, 8'h00, 6'd63, 1'b1, 64'h8098_9FF0_8098_9FF0, 5'd0),
              1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_KEY, 8'h00, 6'd63, 1'b0, 64'h8098_9FF0_8098_9FF0, 5'd16),
              1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_KEY, 8'hFF, 6'd2, 1'b0, '1, 5'd3), 1'b1, '0);
      // three-byte lead whose continuation bytes look like blank and letter
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'hE2, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h20, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h41, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      // stray continuation byte as a character of its own
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h80, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'hFF, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h00, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'hFF, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h09, 6'd0, 1'b0, '0, 5'd0), 1'b1, '0);
      add_row(mk_req(u4dc_pkg::REQ_TEXT, 8'h7A, 6'd0, 1'b0, '0, 5'd0), 1'b0, '0);
      add_row(mk_req(u4dc_pkg::REQ_READ, 8'h00, 6'd0, 1'b0, '0, 5'd0), 1'b0, '0);
      for (i = 0; i < dir_rows.size(); i++)
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].rsp);
      hold_until_drained();

      // random part: seed a few keys, then mostly well-formed text
      for (i = 0; i < 8; i++) write_vocab_key($urandom_range(0, 63));
      while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
         idle_on = !(items_sent >= 400 && items_sent < 600);
         if (items_sent >= 700 && items_sent < 705) hold_until_drained();
         r = $urandom_range(0, 99);
         if (r < 55) begin
            emit_phrase();
         end else if (r < 63) begin
            send_text(8'($urandom_range(0, 255)));
         end else if (r < 67) begin
            // broken character: lead byte only, often cut by a start
            k = $urandom_range(2, 4);
            lead_chars = vocab_bytes(k);
            send_text(lead_chars[7:0]);
            if ($urandom_range(0, 1) == 0)
               send_op(u4dc_pkg::REQ_START, 6'($urandom_range(0, 63)));
         end else if (r < 72) begin
            send_op(u4dc_pkg::REQ_START, 6'($urandom_range(0, 63)));
         end else if (r < 84) begin
            write_vocab_key($urandom_range(0, 63));
         end else if (r < 88) begin
            write_noise_key($urandom_range(0, 63));
         end else begin
            send_op(u4dc_pkg::REQ_READ, 6'($urandom_range(0, 63)));
         end
      end

      // wait for the last answers, then run on for DRAIN_CYCLES
      start    <= 1'b0;
      wait_cnt = 0;
      do begin
         @(negedge clock);
         wait_cnt++;
      end while (awaited_answers.size() != 0 && wait_cnt < 1000);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_answers.size() != 0) begin
         $error("%0d expected results never arrived", awaited_answers.size());
         errors++;
      end
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
